>>> design/time_ordered_command_queue_defines.svh
// ----------------------------------------------------------------------------
// time_ordered_command_queue_defines
// Assertion macros used by the command queue datapath.
// ----------------------------------------------------------------------------
`ifndef TIME_ORDERED_COMMAND_QUEUE_DEFINES_SVH
`define TIME_ORDERED_COMMAND_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define TOCQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tocq assertion failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define TOCQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tocq assertion failed");

`endif

>>> design/tocq_pkg.sv
// ----------------------------------------------------------------------------
// tocq_pkg
// Types and constants of the time-ordered command queue.
// ----------------------------------------------------------------------------
package tocq_pkg;

    localparam int CAPACITY     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int TIME_W       = 32;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PUSH = 2'd1,
        ST_POP  = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [TIME_W-1:0]  entry_time;
        logic [DATA_W-1:0]  entry_payload;
    } in_req_t;

    typedef struct packed {
        status_t            status;
        logic [TIME_W-1:0]  popped_time;
        logic [DATA_W-1:0]  popped_payload;
        logic               head_valid;
        logic [TIME_W-1:0]  head_time;
        logic [DATA_W-1:0]  head_payload;
        logic [OCC_W-1:0]   occupancy;
    } out_rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0]       tkey;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic push_reject;
        logic push_insert;
        logic push_move;
        logic pop_reject;
        logic pop_single;
        logic pop_move;
        logic publish;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_pop;
        logic full;
        logic empty;
        logic one_entry;
        logic insert_here;
        logic pop_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/tocq_ctrl.sv
// ----------------------------------------------------------------------------
// tocq_ctrl
// Sequencer: accepts a request, steps the insert or remove walk, publishes.
// ----------------------------------------------------------------------------
module tocq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tocq_pkg::dp_status_t  st,
    output tocq_pkg::ctrl_cmd_t   cmd
);

    tocq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tocq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tocq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = st.in_pop ? tocq_pkg::ST_POP : tocq_pkg::ST_PUSH;
                end
            end
            tocq_pkg::ST_PUSH: begin
                if (st.full || st.insert_here) begin
                    state_next = tocq_pkg::ST_DONE;
                end
            end
            tocq_pkg::ST_POP: begin
                if (st.empty || st.one_entry || st.pop_last) begin
                    state_next = tocq_pkg::ST_DONE;
                end
            end
            tocq_pkg::ST_DONE: begin
                if (st.out_free) begin
                    state_next = tocq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tocq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            tocq_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            tocq_pkg::ST_PUSH: begin
                if (st.full) begin
                    cmd.push_reject = 1'b1;
                end else if (st.insert_here) begin
                    cmd.push_insert = 1'b1;
                end else begin
                    cmd.push_move = 1'b1;
                end
            end
            tocq_pkg::ST_POP: begin
                if (st.empty) begin
                    cmd.pop_reject = 1'b1;
                end else if (st.one_entry) begin
                    cmd.pop_single = 1'b1;
                end else begin
                    cmd.pop_move = 1'b1;
                end
            end
            tocq_pkg::ST_DONE: begin
                cmd.publish = st.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/tocq_datapath.sv
// ----------------------------------------------------------------------------
// tocq_datapath
// Entry store, count, head cache, walk pointer and result register.
// ----------------------------------------------------------------------------
`include "time_ordered_command_queue_defines.svh"

module tocq_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tocq_pkg::in_req_t     s_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output tocq_pkg::out_rsp_t    m_data,
    input  tocq_pkg::ctrl_cmd_t   cmd,
    output tocq_pkg::dp_status_t  st
);

    // entry store, no reset: only entries below the count are ever used
    tocq_pkg::entry_t mem [tocq_pkg::CAPACITY];

    tocq_pkg::entry_t                  rd_q;
    tocq_pkg::entry_t                  new_entry_reg;
    tocq_pkg::entry_t                  head_reg;
    tocq_pkg::entry_t                  popped_reg;
    tocq_pkg::status_t                 status_reg;
    logic [tocq_pkg::IDX_W-1:0]        pos_reg;
    logic [tocq_pkg::CNT_W-1:0]        count_reg;
    logic                              m_valid_reg;
    tocq_pkg::out_rsp_t                m_data_reg;

    logic                              we;
    logic [tocq_pkg::IDX_W-1:0]        wa;
    logic [tocq_pkg::IDX_W-1:0]        ra;
    tocq_pkg::entry_t                  wd;
    tocq_pkg::out_rsp_t                rsp;
    logic                              has_entry;

    // memory port control
    always_comb begin
        we = 1'b0;
        wa = pos_reg;
        wd = new_entry_reg;
        ra = pos_reg - tocq_pkg::IDX_W'(1);
        if (cmd.load) begin
            if (s_data.op == tocq_pkg::OP_POP) begin
                ra = tocq_pkg::IDX_W'(1);
            end else begin
                ra = tocq_pkg::IDX_W'(count_reg - tocq_pkg::CNT_W'(1));
            end
        end else if (cmd.push_insert) begin
            we = 1'b1;
        end else if (cmd.push_move) begin
            // shift up one place, prefetch the next lower entry
            we = 1'b1;
            wd = rd_q;
            ra = pos_reg - tocq_pkg::IDX_W'(2);
        end else if (cmd.pop_move) begin
            // shift down one place, prefetch the next upper entry
            we = 1'b1;
            wa = pos_reg - tocq_pkg::IDX_W'(1);
            wd = rd_q;
            ra = pos_reg + tocq_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_q <= mem[ra];
    end

    // status to controller
    always_comb begin
        st.in_pop      = (s_data.op == tocq_pkg::OP_POP);
        st.full        = (count_reg == tocq_pkg::CNT_W'(tocq_pkg::CAPACITY));
        st.empty       = (count_reg == '0);
        st.one_entry   = (count_reg == tocq_pkg::CNT_W'(1));
        st.insert_here = (pos_reg == '0) || (rd_q.tkey <= new_entry_reg.tkey);
        st.pop_last    = (tocq_pkg::CNT_W'(pos_reg) == count_reg - tocq_pkg::CNT_W'(1));
        st.out_free    = !m_valid_reg || m_ready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.push_insert) begin
                count_reg <= count_reg + tocq_pkg::CNT_W'(1);
            end else if (cmd.pop_single) begin
                count_reg <= '0;
            end else if (cmd.pop_move && st.pop_last) begin
                count_reg <= count_reg - tocq_pkg::CNT_W'(1);
            end
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            new_entry_reg.tkey    <= s_data.entry_time;
            new_entry_reg.payload <= s_data.entry_payload[tocq_pkg::PAYLOAD_BITS-1:0];
            pos_reg    <= (s_data.op == tocq_pkg::OP_POP) ? tocq_pkg::IDX_W'(1)
                                                          : tocq_pkg::IDX_W'(count_reg);
            status_reg <= tocq_pkg::STATUS_OK;
            popped_reg <= '0;
        end
        if (cmd.push_reject) begin
            status_reg <= tocq_pkg::STATUS_FULL;
        end
        if (cmd.pop_reject) begin
            status_reg <= tocq_pkg::STATUS_EMPTY;
        end
        if (cmd.push_insert && pos_reg == '0) begin
            head_reg <= new_entry_reg;
        end
        if (cmd.push_move) begin
            pos_reg <= pos_reg - tocq_pkg::IDX_W'(1);
        end
        if (cmd.pop_single) begin
            popped_reg <= head_reg;
        end
        if (cmd.pop_move) begin
            if (pos_reg == tocq_pkg::IDX_W'(1)) begin
                popped_reg <= head_reg;
                head_reg   <= rd_q;
            end
            pos_reg <= pos_reg + tocq_pkg::IDX_W'(1);
        end
        if (cmd.publish) begin
            m_data_reg <= rsp;
        end
    end

    // result assembly
    always_comb begin
        has_entry          = (count_reg != '0);
        rsp.status         = status_reg;
        rsp.popped_time    = popped_reg.tkey;
        rsp.popped_payload = tocq_pkg::DATA_W'(popped_reg.payload);
        rsp.head_valid     = has_entry;
        rsp.head_time      = has_entry ? head_reg.tkey : '0;
        rsp.head_payload   = has_entry ? tocq_pkg::DATA_W'(head_reg.payload) : '0;
        rsp.occupancy      = tocq_pkg::OCC_W'(count_reg);
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `TOCQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= tocq_pkg::CNT_W'(tocq_pkg::CAPACITY))
    `TOCQ_ASSERT_NOW(a_publish_free, cmd.publish, !m_valid_reg || m_ready)
    `TOCQ_ASSERT_NOW(a_empty_no_head, m_valid_reg && m_data_reg.status == tocq_pkg::STATUS_EMPTY, !m_data_reg.head_valid)
    `TOCQ_ASSERT_NEXT(a_full_keeps, cmd.push_reject, count_reg == tocq_pkg::CNT_W'(tocq_pkg::CAPACITY))

endmodule

>>> design/time_ordered_command_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_command_queue
// Fixed-capacity queue of (time, payload) entries kept in ascending time order.
// ----------------------------------------------------------------------------
// Each request is a push or a pop and gives exactly one result. A push inserts
// the entry behind every entry of equal or smaller time (ties leave in arrival
// order); a push on a full queue is dropped with status full. A pop returns
// the smallest-time entry and moves the rest forward; a pop on an empty queue
// returns status empty and changes nothing. Every result also carries the head
// entry and the occupancy after the request. Entries live in a one-write,
// one-read RAM, so insert and remove are walks of one entry per cycle through
// that port pair. A push walks down from the tail past every entry with a
// later time, shifting each up one place, then writes the new entry in the
// gap; a push on a full queue is rejected without a walk. A pop shifts every
// entry behind the head forward one place; a pop on an empty or one-entry
// queue needs no walk. Each result is then placed in the output register.
// One request is worked on at a time; the next is taken as soon as the
// previous result is in the output register, even while that result still
// waits for m_ready. The store needs no clearing after reset: the count alone
// says what is valid.
// ----------------------------------------------------------------------------
module time_ordered_command_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tocq_pkg::in_req_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tocq_pkg::out_rsp_t  m_data
);

    tocq_pkg::ctrl_cmd_t   cmd;
    tocq_pkg::dp_status_t  st;

    // sequencer: one state per walk, one to hand off the result
    tocq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // store, head cache, count and the output register
    tocq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .st      (st)
    );

endmodule
